// ===== rtl/core/cinc_pkg.sv =====
// Shared types, field widths and register codes of the cell index and neighbour cell unit.
package cinc_pkg;

   localparam int POS_W       = 32;
   localparam int CELL_W      = 15;
   localparam int CPA_W       = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_PER_AXIS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_CORNER        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_CELL_SIZE = 2'd2;

   // Command codes
   localparam logic CMD_LOCATE    = 1'b0;
   localparam logic CMD_NEIGHBORS = 1'b1;

   localparam logic [POS_W-1:0] INV_CELL_SIZE_RST = 32'h0001_0000;

   typedef struct packed {
      logic                    command;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [CELL_W-1:0]       query_cell;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_number;
      logic              final_item;
      logic              clamped;
   } rsp_type;

   // Classified transaction as it waits between front and back end
   typedef struct packed {
      logic                  nbr;
      logic [2:0]            neg;
      logic [2:0][POS_W-1:0] mag;
      logic [CELL_W-1:0]     query;
   } entry_type;

endpackage

// ===== rtl/core/cell_index_and_neighbor_cells_unit.sv =====
// Top level of the cell index and neighbour cell unit for a periodic cubic cell list.
//
// Request channel (req_*): one transaction per command. A locate command carries a
// Q16.16 point and answers with one result: its cell index and a clamp flag. A
// neighbour command carries a cell index and answers with 27 results, z outermost and
// x innermost, final_item set on the last. Results leave on the rsp_* channel in
// request order. Registers are written on the csr_* channel, which never stalls.
// A locate result passes the front register, the command queue, the locate pipeline
// and the result buffer. Locate commands stream at one per cycle while the sequencer
// is idle and the result buffer has room. A neighbour command holds the back end while
// it clamps the index and splits it into x, y and z by bit-serial division by the cell
// count, then offers one result per cycle while the result buffer has room.
// A neighbour command waits in the queue until earlier locate results have left the
// locate pipeline.
// Reset clears all valid state and loads the register defaults; no clearing pass.
// When the receiver stalls, the two-entry result buffer fills, the back end freezes,
// the command queue fills and then req_ready falls; nothing is lost.
module cell_index_and_neighbor_cells_unit
   import cinc_pkg::*;
#(
   parameter int MAX_CELLS_PER_AXIS = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Coordinate width; n, n^2 and n^3 each need one extra bit to hold the full count
   localparam int CW      = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
   localparam int N_W     = CW + 1;
   localparam int NSQ_W   = 2*CW + 1;
   localparam int NCUBE_W = 3*CW + 1;
   localparam int N_RST   = (MAX_CELLS_PER_AXIS < 32) ? MAX_CELLS_PER_AXIS : 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int OUT_DEPTH   = 2;

   // Configuration: cell count kept in its effective, range-limited form
   logic [N_W-1:0]          n_ff, n_in;
   logic [NSQ_W-1:0]        nsq_ff, nsq_in;
   logic [NCUBE_W-1:0]      ncube_ff, ncube_in;
   logic signed [POS_W-1:0] corner_ff, corner_in;
   logic [POS_W-1:0]        inv_ff, inv_in;
   logic [CPA_W-1:0]        cpa_raw;
   logic                    csr_write;

   logic      front_valid, queue_ready;
   entry_type front_entry;
   logic      head_valid, head_pop;
   entry_type head_entry;

   logic      en;
   logic      loc_start, loc_out_valid, loc_empty;
   rsp_type   loc_rsp;
   logic      nbr_start, nbr_idle, nbr_out_valid;
   rsp_type   nbr_rsp;
   logic      out_push;
   rsp_type   out_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign cpa_raw   = csr_data[CPA_W-1:0];

   always_comb begin
      n_in      = n_ff;
      corner_in = corner_ff;
      inv_in    = inv_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CELLS_PER_AXIS: begin
               // zero counts as one cell, anything above the build limit as the limit
               if (cpa_raw == '0) begin
                  n_in = N_W'(1);
               end else if ({1'b0, cpa_raw} > 7'(MAX_CELLS_PER_AXIS)) begin
                  n_in = N_W'(MAX_CELLS_PER_AXIS);
               end else begin
                  n_in = N_W'(cpa_raw);
               end
            end
            CSR_BOX_CORNER: begin
               corner_in = csr_data;
            end
            CSR_INVERSE_CELL_SIZE: begin
               inv_in = csr_data;
            end
            default: begin
               n_in = n_ff;
            end
         endcase
      end
      // n^2 is registered from n and n^3 from n^2, so both lag a write to n
      nsq_in   = NSQ_W'(n_ff) * NSQ_W'(n_ff);
      ncube_in = NCUBE_W'(nsq_ff) * NCUBE_W'(n_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= N_W'(N_RST);
         nsq_ff    <= NSQ_W'(N_RST * N_RST);
         ncube_ff  <= NCUBE_W'(N_RST * N_RST * N_RST);
         corner_ff <= '0;
         inv_ff    <= INV_CELL_SIZE_RST;
      end else begin
         n_ff      <= n_in;
         nsq_ff    <= nsq_in;
         ncube_ff  <= ncube_in;
         corner_ff <= corner_in;
         inv_ff    <= inv_in;
      end
   end

   // Front end: take the transaction, classify it, form the corner offsets
   cinc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .box_corner  (corner_ff),
      .push_valid  (front_valid),
      .push_ready  (queue_ready),
      .push_entry  (front_entry)
   );

   // Command queue between front and back end
   cinc_fifo #(
      .DATA_W ($bits(entry_type)),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (queue_ready),
      .push_data  (front_entry),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_data   (head_entry)
   );

   // Back end advances whenever the result buffer has room.
   // Dispatch in order: a locate only while the sequencer is idle, a neighbour command
   // only once the locate pipeline has drained, so the two never push together.
   assign loc_start = head_valid && !head_entry.nbr && nbr_idle && en;
   assign nbr_start = head_valid && head_entry.nbr && nbr_idle && loc_empty;
   assign head_pop  = loc_start || nbr_start;

   cinc_locate #(
      .CW (CW)
   ) u_locate (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (loc_start),
      .in_entry      (head_entry),
      .inv_cell_size (inv_ff),
      .n             (n_ff),
      .out_valid     (loc_out_valid),
      .out_rsp       (loc_rsp),
      .empty         (loc_empty)
   );

   cinc_neighbor #(
      .CW (CW)
   ) u_neighbor (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .start     (nbr_start),
      .query     (head_entry.query),
      .n         (n_ff),
      .nsq       (nsq_ff),
      .ncube     (ncube_ff),
      .idle      (nbr_idle),
      .out_valid (nbr_out_valid),
      .out_rsp   (nbr_rsp)
   );

   assign out_push = en && (loc_out_valid || nbr_out_valid);
   assign out_data = loc_out_valid ? loc_rsp : nbr_rsp;

   // Result buffer: parts the back end from the receiver
   cinc_fifo #(
      .DATA_W ($bits(rsp_type)),
      .DEPTH  (OUT_DEPTH)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (out_push),
      .push_ready (en),
      .push_data  (out_data),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_payload)
   );

endmodule

// ===== rtl/core/cinc_fifo.sv =====
// Small synchronous FIFO used as the command queue and as the result buffer.
module cinc_fifo
   import cinc_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2   // power of two
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CNT_W'(count_ff + CNT_W'(push) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/cinc_front.sv =====
// Front end: accepts requests, classifies them and forms the offset from the box corner.
module cinc_front
   import cinc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_payload,
   input  logic signed [POS_W-1:0] box_corner,
   output logic                    push_valid,
   input  logic                    push_ready,
   output entry_type               push_entry
);

   logic                    valid_ff, valid_in;
   entry_type               entry_ff, entry_in;
   logic signed [POS_W-1:0] pos [3];
   logic [POS_W:0]          diff [3];
   logic [POS_W:0]          diff_neg [3];
   logic                    accept;

   assign req_ready  = !valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      pos[0] = req_payload.pos_x;
      pos[1] = req_payload.pos_y;
      pos[2] = req_payload.pos_z;
      entry_in.nbr   = (req_payload.command == CMD_NEIGHBORS);
      entry_in.query = req_payload.query_cell;
      for (int a = 0; a < 3; a++) begin
         // exact 33-bit difference, then sign and magnitude
         diff[a]     = {pos[a][POS_W-1], pos[a]} - {box_corner[POS_W-1], box_corner};
         diff_neg[a] = (POS_W+1)'(0) - diff[a];
         entry_in.neg[a] = diff[a][POS_W];
         entry_in.mag[a] = diff[a][POS_W] ? diff_neg[a][POS_W-1:0] : diff[a][POS_W-1:0];
      end
      valid_in = accept || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== rtl/core/cinc_locate.sv =====
// Locate pipeline: scale, clamp and linearise the three cell coordinates of a point.
module cinc_locate
   import cinc_pkg::*;
#(
   parameter int CW = 5
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  entry_type        in_entry,
   input  logic [POS_W-1:0] inv_cell_size,
   input  logic [CW:0]      n,
   output logic             out_valid,
   output rsp_type          out_rsp,
   output logic             empty
);

   logic [2*POS_W-1:0]     prod [3];

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0]             neg1_ff, neg1_in;
   logic [2:0][POS_W-1:0]  cell1_ff, cell1_in;
   logic [2:0][CW-1:0]     coord2_ff, coord2_in;
   logic                   flag2_ff, flag2_in;
   logic [2*CW-1:0]        t3_ff, t3_in;
   logic [CW-1:0]          x3_ff, x3_in;
   logic                   flag3_ff, flag3_in;
   logic [3*CW-1:0]        idx4_ff, idx4_in;
   logic                   flag4_ff, flag4_in;

   always_comb begin
      // stage 1: integer part of |offset| * inverse cell size
      neg1_in = in_entry.neg;
      for (int a = 0; a < 3; a++) begin
         prod[a]     = (2*POS_W)'(in_entry.mag[a]) * (2*POS_W)'(inv_cell_size);
         cell1_in[a] = prod[a][2*POS_W-1:POS_W];
      end
      // stage 2: clamp into 0..n-1
      flag2_in = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (neg1_ff[a]) begin
            coord2_in[a] = '0;
            if (cell1_ff[a] != '0) begin
               flag2_in = 1'b1;
            end
         end else if (cell1_ff[a] >= POS_W'(n)) begin
            coord2_in[a] = CW'(n - 1'b1);
            flag2_in     = 1'b1;
         end else begin
            coord2_in[a] = cell1_ff[a][CW-1:0];
         end
      end
      // stage 3 and 4: x + n*(y + n*z)
      t3_in    = (2*CW)'(coord2_ff[1]) + (2*CW)'(n) * (2*CW)'(coord2_ff[2]);
      x3_in    = coord2_ff[0];
      flag3_in = flag2_ff;
      idx4_in  = (3*CW)'(x3_ff) + (3*CW)'(n) * (3*CW)'(t3_ff);
      flag4_in = flag3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff   <= neg1_in;
         cell1_ff  <= cell1_in;
         coord2_ff <= coord2_in;
         flag2_ff  <= flag2_in;
         t3_ff     <= t3_in;
         x3_ff     <= x3_in;
         flag3_ff  <= flag3_in;
         idx4_ff   <= idx4_in;
         flag4_ff  <= flag4_in;
      end
   end

   assign out_valid           = v4_ff;
   assign out_rsp.cell_number = CELL_W'(idx4_ff);
   assign out_rsp.final_item  = 1'b1;
   assign out_rsp.clamped     = flag4_ff;
   assign empty               = !(v1_ff || v2_ff || v3_ff || v4_ff);

endmodule

// ===== rtl/core/cinc_neighbor.sv =====
// Neighbour sequencer: clamps a cell index, splits it by bit-serial division and walks the 27 cells.
module cinc_neighbor
   import cinc_pkg::*;
#(
   parameter int CW = 5
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              start,
   input  logic [CELL_W-1:0] query,
   input  logic [CW:0]       n,
   input  logic [2*CW:0]     nsq,
   input  logic [3*CW:0]     ncube,
   output logic              idle,
   output logic              out_valid,
   output rsp_type           out_rsp
);

   localparam int CNT_W = $clog2(2*CW);
   localparam int CMP_W = (CELL_W > 3*CW+1) ? CELL_W : 3*CW+1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLAMP = 3'd1;
   localparam logic [2:0] S_DIV1  = 3'd2;
   localparam logic [2:0] S_DIV2  = 3'd3;
   localparam logic [2:0] S_PREP  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   localparam logic [1:0] OFS_LAST = 2'd2;

   logic [2:0]             state_ff, state_in;
   logic [CELL_W-1:0]      q_ff, q_in;
   logic                   flag_ff, flag_in;
   logic [CW-1:0]          rem_ff, rem_in;
   logic [2*CW-1:0]        shift_ff, shift_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]          x_ff, x_in;
   logic [CW-1:0]          y_ff, y_in;
   logic [2:0][CW-1:0]     xc_ff, xc_in;
   logic [2:0][2*CW-1:0]   yc_ff, yc_in;
   logic [2:0][3*CW-1:0]   zc_ff, zc_in;
   logic [1:0]             dx_ff, dx_in;
   logic [1:0]             dy_ff, dy_in;
   logic [1:0]             dz_ff, dz_in;

   logic [CW:0]            trial, trial_diff;
   logic                   take;
   logic [CW-1:0]          rem_step;
   logic [2*CW-1:0]        shift_step;
   logic [3*CW-1:0]        qc;
   logic                   over;
   logic                   last;
   logic [3*CW-1:0]        sum;

   // periodic neighbour coordinate for offset d-1
   function automatic logic [CW-1:0] wrap_coord(input logic [CW-1:0] c, input logic [1:0] d,
                                                input logic [CW:0] cnt);
      logic [CW-1:0] r;
      unique case (d)
         2'd0:    r = (c == '0) ? CW'(cnt - 1'b1) : CW'(c - 1'b1);
         2'd2:    r = (c == CW'(cnt - 1'b1)) ? '0 : CW'(c + 1'b1);
         default: r = c;
      endcase
      return r;
   endfunction

   always_comb begin
      // one restoring division step by n
      trial      = {rem_ff, shift_ff[2*CW-1]};
      take       = (trial >= n);
      trial_diff = trial - n;
      rem_step   = take ? trial_diff[CW-1:0] : trial[CW-1:0];
      shift_step = {shift_ff[2*CW-2:0], take};

      over = (CMP_W'(q_ff) >= CMP_W'(ncube));
      qc   = over ? (3*CW)'(ncube - 1'b1) : (3*CW)'(q_ff);

      last = (dx_ff == OFS_LAST) && (dy_ff == OFS_LAST) && (dz_ff == OFS_LAST);
      sum  = (3*CW)'(xc_ff[dx_ff]) + (3*CW)'(yc_ff[dy_ff]) + zc_ff[dz_ff];

      state_in = state_ff;
      q_in     = q_ff;
      flag_in  = flag_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      xc_in    = xc_ff;
      yc_in    = yc_ff;
      zc_in    = zc_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dz_in    = dz_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               q_in     = query;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            flag_in  = over;
            rem_in   = qc[3*CW-1:2*CW];
            shift_in = qc[2*CW-1:0];
            cnt_in   = '0;
            state_in = S_DIV1;
         end
         S_DIV1: begin
            rem_in   = rem_step;
            shift_in = shift_step;
            cnt_in   = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(2*CW-1)) begin
               // remainder is x; quotient y + n*z goes round again
               x_in     = rem_step;
               rem_in   = shift_step[2*CW-1:CW];
               shift_in = {shift_step[CW-1:0], {CW{1'b0}}};
               cnt_in   = '0;
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            rem_in   = rem_step;
            shift_in = shift_step;
            cnt_in   = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(CW-1)) begin
               y_in     = rem_step;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            // z sits in the low bits of the quotient
            for (int d = 0; d < 3; d++) begin
               xc_in[d] = wrap_coord(x_ff, 2'(d), n);
               yc_in[d] = (2*CW)'(n) * (2*CW)'(wrap_coord(y_ff, 2'(d), n));
               zc_in[d] = (3*CW)'(nsq) * (3*CW)'(wrap_coord(shift_ff[CW-1:0], 2'(d), n));
            end
            dx_in    = '0;
            dy_in    = '0;
            dz_in    = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (en) begin
               if (dx_ff == OFS_LAST) begin
                  dx_in = '0;
                  if (dy_ff == OFS_LAST) begin
                     dy_in = '0;
                     dz_in = 2'(dz_ff + 1'b1);
                  end else begin
                     dy_in = 2'(dy_ff + 1'b1);
                  end
               end else begin
                  dx_in = 2'(dx_ff + 1'b1);
               end
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      flag_ff  <= flag_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      xc_ff    <= xc_in;
      yc_ff    <= yc_in;
      zc_ff    <= zc_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
   end

   assign idle                = (state_ff == S_IDLE);
   assign out_valid           = (state_ff == S_EMIT);
   assign out_rsp.cell_number = CELL_W'(sum);
   assign out_rsp.final_item  = last;
   assign out_rsp.clamped     = flag_ff;

endmodule

// ===== rtl/core/cinc_checker.sv =====
// Port-level checks on the result stream of the cell index and neighbour cell unit.
module cinc_checker
   import cinc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic [4:0] burst_ff, burst_in;
   logic       clamp_ff, clamp_in;
   logic       take;

   assign take = rsp_valid && rsp_ready;

   // count results since the last final one
   always_comb begin
      burst_in = burst_ff;
      clamp_in = clamp_ff;
      if (take) begin
         burst_in = rsp_payload.final_item ? 5'd0 : 5'(burst_ff + 1'b1);
         clamp_in = rsp_payload.clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= '0;
         clamp_ff <= 1'b0;
      end else begin
         burst_ff <= burst_in;
         clamp_ff <= clamp_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      take && !rsp_payload.final_item |-> burst_ff < 5'd26)
      else $error("neighbour burst longer than 27 results");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      take && rsp_payload.final_item && burst_ff != 5'd0 |-> burst_ff == 5'd26)
      else $error("neighbour burst ended early");

   a_burst_flag: assert property (@(posedge clock) disable iff (reset)
      take && burst_ff != 5'd0 |-> rsp_payload.clamped == clamp_ff)
      else $error("clamp flag changed inside a neighbour burst");

endmodule

bind cell_index_and_neighbor_cells_unit cinc_checker u_cinc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
